// ===== src/pitsr_pkg.sv =====
// Shared types, constants and helpers for the packed index table with swap-and-pop removal.
// Used by pitsr_round and packed_index_table_swap_remove; depends on nothing.
package pitsr_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int OWNER_BITS_DEF = 16;

	localparam int KIND_W     = 3;
	localparam int DATA_W     = 32;
	localparam int OWN_W      = 16;
	localparam int SLOT_W     = 10;
	localparam int OFS_W      = 64;
	localparam int CNT_OUT_W  = 11;
	localparam int CAP_W      = 16;
	localparam int STAT_W     = 2;
	localparam int GRAN_W     = 11;
	localparam int BLK_W      = 7;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 128;
	localparam int M_TDATA_W  = 168;

	localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RESIZE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SYNC   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_GRANULE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS  = 8'd1;

	localparam logic [GRAN_W-1:0] GRAN_RST = 11'd16;
	localparam logic [BLK_W-1:0]  BLK_RST  = 7'd4;
	localparam logic [CAP_W-1:0]  CAP_MAX  = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_ROUND,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             done;
		logic [CAP_W-1:0] result;
	} round_rsp_t;

	// zero granule behaves as one
	function automatic logic [GRAN_W-1:0] granule_eff(input logic [GRAN_W-1:0] g);
		return (g == '0) ? GRAN_W'(1) : g;
	endfunction

	function automatic logic [CAP_W-1:0] load_cap(input logic [GRAN_W-1:0] g,
			input logic [BLK_W-1:0] ib);
		logic [GRAN_W+BLK_W-1:0] p;
		p = (GRAN_W+BLK_W)'(granule_eff(g)) * (GRAN_W+BLK_W)'(ib);
		return (p > (GRAN_W+BLK_W)'(CAP_MAX)) ? CAP_MAX : CAP_W'(p);
	endfunction

endpackage

// ===== src/pitsr_round.sv =====
// Round-up unit: n rounded up to a multiple of the granule, saturated to 16 bits.
// Restoring remainder, one bit of n per cycle. Depends on pitsr_pkg.
module pitsr_round #(
	parameter int NW = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [NW-1:0]                 n,
	input  logic [pitsr_pkg::GRAN_W-1:0]  granule,
	output pitsr_pkg::round_rsp_t         rsp
);

	localparam int CTW = $clog2(NW + 1);
	localparam int SW  = ((NW > pitsr_pkg::GRAN_W) ? NW : pitsr_pkg::GRAN_W) + 1;

	logic                         busy_q;
	logic [CTW-1:0]               cnt_q;
	logic [NW-1:0]                shf_q;
	logic [NW-1:0]                nk_q;
	logic [pitsr_pkg::GRAN_W-1:0] g_q;
	logic [pitsr_pkg::GRAN_W-1:0] rem_q;
	logic [pitsr_pkg::GRAN_W:0]   trial;
	logic [pitsr_pkg::GRAN_W-1:0] rem_next;
	logic [SW-1:0]                up;

	always_comb begin
		trial = {rem_q, shf_q[NW-1]};
		rem_next = (trial >= {1'b0, g_q}) ? pitsr_pkg::GRAN_W'(trial - {1'b0, g_q})
			: pitsr_pkg::GRAN_W'(trial);
		up = (rem_q == '0) ? SW'(nk_q) : SW'(nk_q) - SW'(rem_q) + SW'(g_q);
		rsp.done = busy_q && (cnt_q == '0);
		rsp.result = (32'(up) > 32'(pitsr_pkg::CAP_MAX)) ? pitsr_pkg::CAP_MAX
			: pitsr_pkg::CAP_W'(up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CTW'(NW);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= n;
			nk_q  <= n;
			g_q   <= granule;
			rem_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			shf_q <= shf_q << 1;
			rem_q <= rem_next;
		end
	end

endmodule

// ===== src/packed_index_table_swap_remove.sv =====
// Top level of the packed index table: request sequencer, entry memories, result register.
// Depends on pitsr_pkg and pitsr_round.
//
// channel  | direction | handshake          | content
// s_*      | in        | s_tvalid/s_tready  | one request: kind in tuser, operands in tdata
// m_*      | out       | m_tvalid/m_tready  | one result per request, status in tuser
// cfg_*    | in        | cfg_valid/cfg_ready| register index and write data, always ready
//
// Add and sync go from idle to the finish state; remove and read pass the read state
// first (not on a bad slot or a remove of the last slot); an add that grows the capacity
// and a resize wait in the round state for the one-bit-per-cycle remainder loop of
// pitsr_round over NW = clog2(DEPTH + 1) + 1 bits (12 at the default depth).
// One request at a time; s_tready is low while a request is in flight.
// A finished result waits in the output register; the next request is taken meanwhile.
// Entry memories have no reset and no clearing pass; only slots below the count are read.
module packed_index_table_swap_remove #(
	parameter int DEPTH      = pitsr_pkg::DEPTH_DEF,
	parameter int OWNER_BITS = pitsr_pkg::OWNER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// data_value, has_owner, owner_id, slot, new_offset, zero pad
	input  logic [pitsr_pkg::S_TDATA_W-1:0]   s_tdata,
	// kind
	input  logic [pitsr_pkg::KIND_W-1:0]      s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// notify_valid, notify_owner, notify_slot, read_value, entry_count, capacity_now,
	// synced_capacity, dirty, offset_now, zero pad
	output logic [pitsr_pkg::M_TDATA_W-1:0]   m_tdata,
	// status
	output logic [pitsr_pkg::STAT_W-1:0]      m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pitsr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pitsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int NW   = CW + 1;
	localparam int CMPW = (CW > pitsr_pkg::SLOT_W) ? CW : pitsr_pkg::SLOT_W;

	pitsr_pkg::state_t state_q, state_d;

	logic [CW-1:0]                    count_q;
	logic [pitsr_pkg::CAP_W-1:0]      cap_q;
	logic [pitsr_pkg::CAP_W-1:0]      snap_q;
	logic                             dirty_q;
	logic [pitsr_pkg::OFS_W-1:0]      ofs_q;
	logic [pitsr_pkg::GRAN_W-1:0]     gran_q;
	logic [pitsr_pkg::BLK_W-1:0]      blk_q;

	logic                             is_add_q;
	logic                             is_rm_q;
	logic [pitsr_pkg::SLOT_W-1:0]     slot_q;
	logic                             nvalid_q;
	logic [pitsr_pkg::OWN_W-1:0]      nowner_q;
	logic [pitsr_pkg::SLOT_W-1:0]     nslot_q;
	logic [pitsr_pkg::DATA_W-1:0]     rval_q;
	logic [pitsr_pkg::STAT_W-1:0]     status_q;

	logic                             out_valid_q;
	logic [pitsr_pkg::M_TDATA_W-1:0]  out_data_q;
	logic [pitsr_pkg::STAT_W-1:0]     out_stat_q;

	logic [pitsr_pkg::DATA_W-1:0]     data_mem [DEPTH];
	logic [OWNER_BITS:0]              owner_mem [DEPTH];
	logic [pitsr_pkg::DATA_W-1:0]     data_rd_q;
	logic [OWNER_BITS:0]              owner_rd_q;

	logic [pitsr_pkg::KIND_W-1:0]     in_kind;
	logic [pitsr_pkg::DATA_W-1:0]     in_data;
	logic                             in_has;
	logic [pitsr_pkg::OWN_W-1:0]      in_owner;
	logic [pitsr_pkg::SLOT_W-1:0]     in_slot;
	logic [pitsr_pkg::OFS_W-1:0]      in_ofs;
	logic [OWNER_BITS-1:0]            owner_in;

	logic                             acc;
	logic                             full;
	logic                             bad_slot;
	logic [CW-1:0]                    last;
	logic                             grow;
	logic                             mem_we;
	logic [AW-1:0]                    mem_wa;
	logic [pitsr_pkg::DATA_W-1:0]     mem_wd;
	logic [OWNER_BITS:0]              mem_wo;
	logic [AW-1:0]                    mem_ra;
	logic                             rnd_start;
	logic [NW-1:0]                    rnd_n;
	pitsr_pkg::round_rsp_t            rnd_rsp;
	logic                             fin_load;

	assign in_kind  = s_tuser;
	assign in_data  = s_tdata[31:0];
	assign in_has   = s_tdata[32];
	assign in_owner = s_tdata[48:33];
	assign in_slot  = s_tdata[58:49];
	assign in_ofs   = s_tdata[122:59];
	assign owner_in = OWNER_BITS'(in_owner);

	assign s_tready  = (state_q == pitsr_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign acc       = s_tvalid && s_tready;
	assign full      = (count_q == CW'(DEPTH));
	assign bad_slot  = (CMPW'(in_slot) >= CMPW'(count_q));
	assign last      = count_q - CW'(1);
	assign grow      = (32'(count_q) + 32'd1 >= 32'(cap_q));
	assign fin_load  = (state_q == pitsr_pkg::ST_FIN) && (!out_valid_q || m_tready);

	assign rnd_start = acc && (((in_kind == pitsr_pkg::KIND_ADD) && !full && grow)
		|| (in_kind == pitsr_pkg::KIND_RESIZE));
	assign rnd_n = (in_kind == pitsr_pkg::KIND_ADD) ? NW'(count_q) + NW'(2) : NW'(count_q);

	assign mem_ra = (in_kind == pitsr_pkg::KIND_REMOVE) ? AW'(last) : AW'(in_slot);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = AW'(count_q);
		mem_wd = in_data;
		mem_wo = {in_has, owner_in};
		if (acc && (in_kind == pitsr_pkg::KIND_ADD) && !full) begin
			mem_we = 1'b1;
		end else if ((state_q == pitsr_pkg::ST_READ) && is_rm_q) begin
			mem_we = 1'b1;
			mem_wa = AW'(slot_q);
			mem_wd = data_rd_q;
			mem_wo = owner_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			data_mem[mem_wa]  <= mem_wd;
			owner_mem[mem_wa] <= mem_wo;
		end
		data_rd_q  <= data_mem[mem_ra];
		owner_rd_q <= owner_mem[mem_ra];
	end

	pitsr_round #(
		.NW(NW)
	) u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rnd_start),
		.n      (rnd_n),
		.granule(pitsr_pkg::granule_eff(gran_q)),
		.rsp    (rnd_rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pitsr_pkg::ST_IDLE: begin
				if (acc) begin
					state_d = pitsr_pkg::ST_FIN;
					if (rnd_start) begin
						state_d = pitsr_pkg::ST_ROUND;
					end else if ((in_kind == pitsr_pkg::KIND_REMOVE) && !bad_slot
							&& (CW'(in_slot) != last)) begin
						state_d = pitsr_pkg::ST_READ;
					end else if ((in_kind == pitsr_pkg::KIND_READ) && !bad_slot) begin
						state_d = pitsr_pkg::ST_READ;
					end
				end
			end
			pitsr_pkg::ST_READ: begin
				state_d = pitsr_pkg::ST_FIN;
			end
			pitsr_pkg::ST_ROUND: begin
				if (rnd_rsp.done) begin
					state_d = pitsr_pkg::ST_FIN;
				end
			end
			pitsr_pkg::ST_FIN: begin
				if (fin_load) begin
					state_d = pitsr_pkg::ST_IDLE;
				end
			end
			default: state_d = pitsr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pitsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= pitsr_pkg::load_cap(pitsr_pkg::GRAN_RST, pitsr_pkg::BLK_RST);
			snap_q  <= pitsr_pkg::load_cap(pitsr_pkg::GRAN_RST, pitsr_pkg::BLK_RST);
			dirty_q <= 1'b0;
			ofs_q   <= '0;
			gran_q  <= pitsr_pkg::GRAN_RST;
			blk_q   <= pitsr_pkg::BLK_RST;
		end else begin
			if (cfg_valid && (cfg_index == pitsr_pkg::CFG_GRANULE)) begin
				gran_q <= pitsr_pkg::GRAN_W'(cfg_data);
				cap_q  <= pitsr_pkg::load_cap(pitsr_pkg::GRAN_W'(cfg_data), blk_q);
				snap_q <= pitsr_pkg::load_cap(pitsr_pkg::GRAN_W'(cfg_data), blk_q);
			end else if (cfg_valid && (cfg_index == pitsr_pkg::CFG_BLOCKS)) begin
				blk_q  <= pitsr_pkg::BLK_W'(cfg_data);
				cap_q  <= pitsr_pkg::load_cap(gran_q, pitsr_pkg::BLK_W'(cfg_data));
				snap_q <= pitsr_pkg::load_cap(gran_q, pitsr_pkg::BLK_W'(cfg_data));
			end
			if (acc) begin
				if ((in_kind == pitsr_pkg::KIND_ADD) && !full) begin
					count_q <= count_q + CW'(1);
					dirty_q <= 1'b1;
				end else if ((in_kind == pitsr_pkg::KIND_REMOVE) && !bad_slot) begin
					count_q <= last;
					dirty_q <= 1'b1;
				end else if (in_kind == pitsr_pkg::KIND_RESIZE) begin
					dirty_q <= 1'b1;
				end else if (in_kind == pitsr_pkg::KIND_SYNC) begin
					ofs_q   <= in_ofs;
					snap_q  <= cap_q;
					dirty_q <= 1'b0;
				end
			end
			if ((state_q == pitsr_pkg::ST_ROUND) && rnd_rsp.done) begin
				if (is_add_q || (rnd_rsp.result > cap_q)) begin
					cap_q <= rnd_rsp.result;
				end
			end
		end
	end

	// per-request result fields
	always_ff @(posedge clk) begin
		if (acc) begin
			is_add_q <= (in_kind == pitsr_pkg::KIND_ADD);
			is_rm_q  <= (in_kind == pitsr_pkg::KIND_REMOVE);
			slot_q   <= in_slot;
			nvalid_q <= 1'b0;
			nowner_q <= '0;
			nslot_q  <= '0;
			rval_q   <= '0;
			status_q <= pitsr_pkg::STAT_OK;
			if (in_kind == pitsr_pkg::KIND_ADD) begin
				if (full) begin
					status_q <= pitsr_pkg::STAT_FULL;
				end else if (in_has) begin
					nvalid_q <= 1'b1;
					nowner_q <= pitsr_pkg::OWN_W'(owner_in);
					nslot_q  <= pitsr_pkg::SLOT_W'(count_q);
				end
			end else if ((in_kind == pitsr_pkg::KIND_REMOVE)
					|| (in_kind == pitsr_pkg::KIND_READ)) begin
				if (bad_slot) begin
					status_q <= pitsr_pkg::STAT_BAD;
				end
			end
		end else if (state_q == pitsr_pkg::ST_READ) begin
			if (is_rm_q) begin
				if (owner_rd_q[OWNER_BITS]) begin
					nvalid_q <= 1'b1;
					nowner_q <= pitsr_pkg::OWN_W'(owner_rd_q[OWNER_BITS-1:0]);
					nslot_q  <= slot_q;
				end
			end else begin
				rval_q <= data_rd_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_stat_q <= status_q;
			out_data_q <= {1'b0, ofs_q, dirty_q, snap_q, cap_q,
				pitsr_pkg::CNT_OUT_W'(count_q), rval_q, nslot_q, nowner_q, nvalid_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_stat_q;

endmodule
